// ===== hw/rtl/swm_pkg.sv =====
// -----------------------------------------------------------------------------
// swm_pkg
// Shared types, constants and the cosine table builder for the sample window
// multiplier.
// -----------------------------------------------------------------------------
package swm_pkg;

   localparam int unsigned MAX_FRAME_DEF      = 4096;
   localparam int unsigned COS_TABLE_BITS_DEF = 10;
   localparam int unsigned SAMPLE_BITS_DEF    = 16;

   localparam int unsigned INDEX_W  = 12;
   localparam int unsigned WTYPE_W  = 2;
   localparam int unsigned FLEN_W   = 13;
   localparam int unsigned PSTEP_W  = 33;
   localparam int unsigned PHASE_W  = 32;
   localparam int unsigned CSR_AW   = 2;
   localparam int unsigned COS_W    = 31;
   localparam int unsigned KCOEF_W  = 30;

   localparam logic [CSR_AW-1:0] CSR_WINDOW_TYPE  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_FRAME_LENGTH = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_PHASE_STEP   = 2'd2;

   localparam logic [WTYPE_W-1:0] WIN_RECT     = 2'd0;
   localparam logic [WTYPE_W-1:0] WIN_HAMMING  = 2'd1;
   localparam logic [WTYPE_W-1:0] WIN_HANN     = 2'd2;
   localparam logic [WTYPE_W-1:0] WIN_BLACKMAN = 2'd3;

   localparam logic [WTYPE_W-1:0] WTYPE_RST = WIN_RECT;
   localparam logic [FLEN_W-1:0]  FLEN_RST  = 13'd4096;
   localparam logic [31:0]        PSTEP_RST = 32'd1048832;

   localparam logic [COS_W-1:0]   Q30_ONE = 31'd1073741824;
   localparam logic [KCOEF_W-1:0] C_HAM0  = 30'd579820585;
   localparam logic [KCOEF_W-1:0] C_HAM1  = 30'd493921239;
   localparam logic [KCOEF_W-1:0] C_HALF  = 30'd536870912;
   localparam logic [KCOEF_W-1:0] C_BLK0  = 30'd450971566;
   localparam logic [KCOEF_W-1:0] C_BLK1  = 30'd536870912;
   localparam logic [KCOEF_W-1:0] C_BLK2  = 30'd85899346;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_64      = 64'd1073741824;
   localparam logic [63:0] HALF_Q30    = 64'd536870912;

   typedef struct packed {
      logic [COS_W-1:0] mag1;
      logic             neg1;
      logic [COS_W-1:0] mag2;
      logic             neg2;
   } cos_pair_type;

   function automatic logic [63:0] taylor_sub(input logic [63:0] s);
      return (s > ONE_64) ? 64'd0 : ONE_64 - s;
   endfunction

   function automatic logic [63:0] q30_mul(input logic [63:0] y, input logic [63:0] t);
      return (y * t + HALF_Q30) >> 30;
   endfunction

   // cos(pi/2 * k / 2^bits) in Q1.30 by a nested Taylor series
   function automatic logic [COS_W-1:0] cos_entry(input int unsigned k,
                                                  input int unsigned bits);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] t;
      logic [63:0] s;
      x = (HALF_PI_Q30 * 64'(k) + ((64'd1 << bits) >> 1)) >> bits;
      y = q30_mul(x, x);
      t = ONE_64;
      s = q30_mul(y, t); s = (s + 64'd120) / 64'd240; t = taylor_sub(s);
      s = q30_mul(y, t); s = (s + 64'd91)  / 64'd182; t = taylor_sub(s);
      s = q30_mul(y, t); s = (s + 64'd66)  / 64'd132; t = taylor_sub(s);
      s = q30_mul(y, t); s = (s + 64'd45)  / 64'd90;  t = taylor_sub(s);
      s = q30_mul(y, t); s = (s + 64'd28)  / 64'd56;  t = taylor_sub(s);
      s = q30_mul(y, t); s = (s + 64'd15)  / 64'd30;  t = taylor_sub(s);
      s = q30_mul(y, t); s = (s + 64'd6)   / 64'd12;  t = taylor_sub(s);
      s = q30_mul(y, t); s = (s + 64'd1)   / 64'd2;   t = taylor_sub(s);
      return t[COS_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/swm_cos_lut.sv =====
// -----------------------------------------------------------------------------
// swm_cos_lut
// Quarter-wave cosine table with two registered lookups: cos of the phase and
// cos of twice the phase, returned as magnitude and sign.
// -----------------------------------------------------------------------------
module swm_cos_lut #(
   parameter int unsigned COS_TABLE_BITS = swm_pkg::COS_TABLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [swm_pkg::PHASE_W-1:0]  phase,
   output swm_pkg::cos_pair_type        pair_ff
);

   localparam int unsigned TBL_N  = 1 << COS_TABLE_BITS;
   localparam int unsigned ADDR_W = COS_TABLE_BITS + 1;
   localparam int unsigned RND    = 1 << (29 - COS_TABLE_BITS);

   logic [swm_pkg::COS_W-1:0] rom_tbl [TBL_N+1];

   for (genvar k = 0; k <= TBL_N; k++) begin : g_rom
      assign rom_tbl[k] = swm_pkg::cos_entry(k, COS_TABLE_BITS);
   end

   logic [swm_pkg::PHASE_W-1:0] phase2;
   logic [ADDR_W-1:0]           addr1;
   logic [ADDR_W-1:0]           addr2;
   logic                        neg1;
   logic                        neg2;
   swm_pkg::cos_pair_type       pair_in;

   function automatic logic [ADDR_W-1:0] quad_addr(input logic [swm_pkg::PHASE_W-1:0] ph);
      logic [30:0]       sum;
      logic [ADDR_W-1:0] p;
      sum = {1'b0, ph[29:0]} + 31'(RND);
      p   = sum[30:30-COS_TABLE_BITS];
      if (p > ADDR_W'(TBL_N)) begin
         p = ADDR_W'(TBL_N);
      end
      return ph[30] ? ADDR_W'(TBL_N) - p : p;
   endfunction

   assign phase2 = {phase[swm_pkg::PHASE_W-2:0], 1'b0};
   assign addr1  = quad_addr(phase);
   assign addr2  = quad_addr(phase2);
   assign neg1   = phase[31] ^ phase[30];
   assign neg2   = phase2[31] ^ phase2[30];

   always_comb begin
      pair_in.mag1 = rom_tbl[addr1];
      pair_in.neg1 = neg1;
      pair_in.mag2 = rom_tbl[addr2];
      pair_in.neg2 = neg2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pair_ff <= pair_in;
      end
   end

endmodule

// ===== hw/rtl/sample_window_multiplier_unit.sv =====
// Throughput: one word per cycle while rsp is not stalled; the phase multiply,
// table read, coefficient multiply, coefficient sum, sample multiply and rounding
// each own one stage.
// Stalls collapse bubbles; a held rsp word blocks req only once every stage is full.
// Reset (synchronous): empties the pipeline and loads window_type 0,
// frame_length 4096, phase_step 1048832.
// -----------------------------------------------------------------------------
// sample_window_multiplier_unit
// Multiplies each sample by a rectangular, Hamming, Hann or Blackman window
// coefficient in a six-stage pipeline.
// -----------------------------------------------------------------------------
module sample_window_multiplier_unit #(
   parameter int unsigned MAX_FRAME      = swm_pkg::MAX_FRAME_DEF,
   parameter int unsigned COS_TABLE_BITS = swm_pkg::COS_TABLE_BITS_DEF,
   parameter int unsigned SAMPLE_BITS    = swm_pkg::SAMPLE_BITS_DEF,
   localparam int unsigned REQ_DATA_W = ((SAMPLE_BITS + swm_pkg::INDEX_W + 7) / 8) * 8,
   localparam int unsigned RSP_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [REQ_DATA_W-1:0]         req_tdata,   // sample, sample_index
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_DATA_W-1:0]         rsp_tdata,   // windowed_sample
   output logic                          rsp_tuser,   // index_error
   input  logic                          csr_we,
   input  logic [swm_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [swm_pkg::PSTEP_W-1:0]   csr_wdata
);

   localparam int unsigned SB     = SAMPLE_BITS;
   localparam int unsigned PROD_W = SAMPLE_BITS + 32;
   localparam int unsigned NST    = 6;
   localparam logic signed [PROD_W-1:0] SMAX = (PROD_W'(1) <<< (SB - 1)) - PROD_W'(1);
   localparam logic signed [PROD_W-1:0] SMIN = -SMAX - PROD_W'(1);
   localparam logic signed [PROD_W-1:0] RND  = PROD_W'(1) <<< 29;

   logic [swm_pkg::WTYPE_W-1:0] wtype_ff, wtype_in;
   logic [swm_pkg::FLEN_W-1:0]  flen_ff, flen_in;
   logic [31:0]                 pstep_ff, pstep_in;

   logic [NST:1] vld_ff, vld_in;
   logic [NST:1] adv;

   logic [SB-1:0]                req_sample;
   logic [swm_pkg::INDEX_W-1:0]  req_index;
   logic [43:0]                  phase_full;

   logic [swm_pkg::PHASE_W-1:0]  s1_phase_ff, s1_phase_in;
   logic [SB-1:0]                s1_smp_ff, s2_smp_ff, s3_smp_ff, s4_smp_ff;
   logic                         s1_err_ff, s1_err_in;
   logic                         s2_err_ff, s3_err_ff, s4_err_ff, s5_err_ff;
   swm_pkg::cos_pair_type        s2_pair;

   logic [swm_pkg::KCOEF_W-1:0]  k1;
   logic [60:0]                  m1;
   logic [60:0]                  m2;
   logic [swm_pkg::COS_W-1:0]    s3_r1_ff, s3_r1_in;
   logic [swm_pkg::COS_W-1:0]    s3_r2_ff, s3_r2_in;
   logic                         s3_neg1_ff, s3_neg2_ff;

   logic signed [32:0]           term1;
   logic signed [32:0]           term2;
   logic signed [32:0]           coef_sum;
   logic [swm_pkg::COS_W-1:0]    s4_coef_ff, s4_coef_in;

   logic signed [PROD_W-1:0]     s5_prod_ff, s5_prod_in;
   logic signed [PROD_W-1:0]     shifted;
   logic [SB-1:0]                s6_ws_ff, s6_ws_in;
   logic                         s6_err_ff;

   // configuration
   always_comb begin
      wtype_in = wtype_ff;
      flen_in  = flen_ff;
      pstep_in = pstep_ff;
      if (csr_we) begin
         case (csr_addr)
            swm_pkg::CSR_WINDOW_TYPE:  wtype_in = csr_wdata[swm_pkg::WTYPE_W-1:0];
            swm_pkg::CSR_FRAME_LENGTH: flen_in  = csr_wdata[swm_pkg::FLEN_W-1:0];
            swm_pkg::CSR_PHASE_STEP:   pstep_in = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // pipeline flow
   always_comb begin
      adv[NST] = !vld_ff[NST] || rsp_tready;
      for (int k = NST - 1; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[1] = adv[1] ? req_tvalid : vld_ff[1];
      for (int k = 2; k <= NST; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign req_tready = adv[1];

   // stage 1: phase and range check
   assign req_sample  = req_tdata[SB-1:0];
   assign req_index   = req_tdata[SB +: swm_pkg::INDEX_W];
   assign phase_full  = 44'(req_index) * 44'(pstep_ff);
   assign s1_phase_in = phase_full[31:0];
   assign s1_err_in   = ({1'b0, req_index} >= flen_ff) || (32'(req_index) >= 32'(MAX_FRAME));

   // stage 2: table lookup
   swm_cos_lut #(
      .COS_TABLE_BITS (COS_TABLE_BITS)
   ) u_cos_lut (
      .clock   (clock),
      .en      (adv[2]),
      .phase   (s1_phase_ff),
      .pair_ff (s2_pair)
   );

   // stage 3: cosine terms, rounded half away from zero on the magnitude
   always_comb begin
      case (wtype_ff)
         swm_pkg::WIN_HAMMING:  k1 = swm_pkg::C_HAM1;
         swm_pkg::WIN_HANN:     k1 = swm_pkg::C_HALF;
         swm_pkg::WIN_BLACKMAN: k1 = swm_pkg::C_BLK1;
         default:               k1 = swm_pkg::C_HALF;
      endcase
      m1 = 61'(k1) * 61'(s2_pair.mag1);
      m2 = 61'(swm_pkg::C_BLK2) * 61'(s2_pair.mag2);
      s3_r1_in = swm_pkg::COS_W'((m1 + 61'(swm_pkg::HALF_Q30)) >> 30);
      s3_r2_in = swm_pkg::COS_W'((m2 + 61'(swm_pkg::HALF_Q30)) >> 30);
   end

   // stage 4: coefficient sum and clamp
   always_comb begin
      term1 = s3_neg1_ff ? $signed({2'b00, s3_r1_ff}) : -$signed({2'b00, s3_r1_ff});
      term2 = s3_neg2_ff ? -$signed({2'b00, s3_r2_ff}) : $signed({2'b00, s3_r2_ff});
      case (wtype_ff)
         swm_pkg::WIN_HAMMING:  coef_sum = $signed({3'b000, swm_pkg::C_HAM0}) + term1;
         swm_pkg::WIN_HANN:     coef_sum = $signed({3'b000, swm_pkg::C_HALF}) + term1;
         swm_pkg::WIN_BLACKMAN: coef_sum = $signed({3'b000, swm_pkg::C_BLK0}) + term1 + term2;
         default:               coef_sum = $signed({2'b00, swm_pkg::Q30_ONE});
      endcase
      if (coef_sum < 0) begin
         s4_coef_in = '0;
      end else if (coef_sum > $signed({2'b00, swm_pkg::Q30_ONE})) begin
         s4_coef_in = swm_pkg::Q30_ONE;
      end else begin
         s4_coef_in = coef_sum[swm_pkg::COS_W-1:0];
      end
   end

   // stage 5: sample product
   assign s5_prod_in = $signed(s4_smp_ff) * $signed({1'b0, s4_coef_ff});

   // stage 6: round, saturate, zero on index error
   always_comb begin
      shifted = (s5_prod_ff + RND) >>> 30;
      if (s5_err_ff) begin
         s6_ws_in = '0;
      end else if (shifted > SMAX) begin
         s6_ws_in = SMAX[SB-1:0];
      end else if (shifted < SMIN) begin
         s6_ws_in = SMIN[SB-1:0];
      end else begin
         s6_ws_in = shifted[SB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wtype_ff <= swm_pkg::WTYPE_RST;
         flen_ff  <= swm_pkg::FLEN_RST;
         pstep_ff <= swm_pkg::PSTEP_RST;
         vld_ff   <= '0;
      end else begin
         wtype_ff <= wtype_in;
         flen_ff  <= flen_in;
         pstep_ff <= pstep_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_phase_ff <= s1_phase_in;
         s1_smp_ff   <= req_sample;
         s1_err_ff   <= s1_err_in;
      end
      if (adv[2]) begin
         s2_smp_ff <= s1_smp_ff;
         s2_err_ff <= s1_err_ff;
      end
      if (adv[3]) begin
         s3_r1_ff   <= s3_r1_in;
         s3_r2_ff   <= s3_r2_in;
         s3_neg1_ff <= s2_pair.neg1;
         s3_neg2_ff <= s2_pair.neg2;
         s3_smp_ff  <= s2_smp_ff;
         s3_err_ff  <= s2_err_ff;
      end
      if (adv[4]) begin
         s4_coef_ff <= s4_coef_in;
         s4_smp_ff  <= s3_smp_ff;
         s4_err_ff  <= s3_err_ff;
      end
      if (adv[5]) begin
         s5_prod_ff <= s5_prod_in;
         s5_err_ff  <= s4_err_ff;
      end
      if (adv[6]) begin
         s6_ws_ff  <= s6_ws_in;
         s6_err_ff <= s5_err_ff;
      end
   end

   assign rsp_tvalid = vld_ff[NST];
   assign rsp_tdata  = RSP_DATA_W'(s6_ws_ff);
   assign rsp_tuser  = s6_err_ff;

endmodule

// ===== hw/rtl/swm_checker.sv =====
// -----------------------------------------------------------------------------
// swm_checker
// Port-level checks for the sample window multiplier, bound to the top level.
// -----------------------------------------------------------------------------
module swm_checker #(
   parameter int unsigned RSP_DATA_W = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("index error word carries nonzero data");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp word changed");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp word valid right after reset");

   a_ready_when_drained : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("req stalled while the output moves");

endmodule

bind sample_window_multiplier_unit swm_checker #(
   .RSP_DATA_W (RSP_DATA_W)
) u_swm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
